// ===== design/b64ms_pkg.sv =====
// ----------------------------------------------------------------------------
// Base64 decode and markup strip: shared definitions
// Constants, character codes and the types that pass between the front end,
// the queue and the back end of the decoder.
// ----------------------------------------------------------------------------
package b64ms_pkg;

  // Filter limits.
  localparam int ENTITY_MAX = 14;
  localparam int TAG_MAX    = 32;
  localparam int HEAD_LEN   = 4;

  // Decoupling queue between decoder and filter (a power of two).
  localparam int QUEUE_DEPTH = 4;

  // Derived widths.
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int ECNT_W     = $clog2(ENTITY_MAX + 1);
  localparam int EIDX_W     = $clog2(ENTITY_MAX);
  localparam int TCNT_W     = $clog2(TAG_MAX + 1);
  localparam int HEAD_IDX_W = $clog2(HEAD_LEN);

  // Character codes.
  localparam logic [7:0] CH_PAD  = "=";
  localparam logic [7:0] CH_LT   = "<";
  localparam logic [7:0] CH_GT   = ">";
  localparam logic [7:0] CH_AMP  = "&";
  localparam logic [7:0] CH_SEMI = ";";
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SP   = " ";

  // One decoded item handed from the front end to the back end.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } q_entry_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
    logic              full;
  } q_status_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    B_RUN,
    B_FLUSH,
    B_TAIL
  } back_state_t;

  // Back end status.
  typedef struct packed {
    logic pop;
    logic flushing;
  } back_status_t;

endpackage

// ===== design/b64ms_front.sv =====
// ----------------------------------------------------------------------------
// Base64 decode front end
// Accepts one encoded character per transfer, decodes both alphabets and
// queues each decoded byte, plus an entry for every end-of-payload marker.
// ----------------------------------------------------------------------------
module b64ms_front
  import b64ms_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       push,
  output q_entry_t   push_entry,
  input  q_status_t  q_status
);

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sym_t;

  // Symbol lookup covering the standard and URL-safe alphabets.
  function automatic sym_t sym_decode(input logic [7:0] c);
    sym_t s;
    s.valid = 1'b1;
    s.value = '0;
    if (c inside {["A":"Z"]}) begin
      s.value = 6'(c - "A");
    end else if (c inside {["a":"z"]}) begin
      s.value = 6'(c - "a" + 8'd26);
    end else if (c inside {["0":"9"]}) begin
      s.value = 6'(c - "0" + 8'd52);
    end else if (c == "-" || c == "+") begin
      s.value = 6'd62;
    end else if (c == "_" || c == "/") begin
      s.value = 6'd63;
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

  logic [11:0] accum;
  logic [11:0] accum_next;
  logic [3:0]  level;
  logic [3:0]  level_next;
  logic        stopped;
  logic        stopped_next;

  logic        accept;
  sym_t        sym;
  logic [11:0] accum_shift;
  logic [3:0]  level_add;
  logic        decode_en;
  logic        byte_ready;
  logic [7:0]  dec_byte;

  // The queue must have room for the entry this character may cause.
  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  // Decode datapath: six bits in, the oldest eight out once enough are held.
  always_comb begin
    sym         = sym_decode(in_char);
    accum_shift = {accum[5:0], sym.value};
    level_add   = level + 4'd6;
    decode_en   = !stopped && (in_char != CH_PAD) && sym.valid;
    byte_ready  = decode_en && level_add[3];
    dec_byte    = 8'(accum_shift >> level_add[2:0]);
  end

  // Queue entry for a decoded byte or for the end of the payload.
  always_comb begin
    push                = accept && (byte_ready || in_last);
    push_entry.data     = dec_byte;
    push_entry.has_byte = byte_ready;
    push_entry.last     = in_last;
  end

  // Next values of the decoder state.
  always_comb begin
    accum_next   = accum;
    level_next   = level;
    stopped_next = stopped;
    if (accept) begin
      if (in_last) begin
        accum_next   = '0;
        level_next   = '0;
        stopped_next = 1'b0;
      end else if (in_char == CH_PAD) begin
        stopped_next = 1'b1;
      end else if (decode_en) begin
        accum_next = accum_shift;
        level_next = byte_ready ? {1'b0, level_add[2:0]} : level_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum   <= '0;
      level   <= '0;
      stopped <= 1'b0;
    end else begin
      accum   <= accum_next;
      level   <= level_next;
      stopped <= stopped_next;
    end
  end

endmodule

// ===== design/b64ms_queue.sv =====
// ----------------------------------------------------------------------------
// Decoupling queue
// A short register queue that lets the decoder keep taking characters while
// the filter works through an entity flush.
// ----------------------------------------------------------------------------
module b64ms_queue
  import b64ms_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t status
);

  q_entry_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;

  assign head         = entries[rd_ptr];
  assign status.count = count;
  assign status.empty = (count == '0);
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));

  // Occupancy follows the push and pop transfers.
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + QCNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - QCNT_W'(1);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
    end
  end

endmodule

// ===== design/b64ms_back.sv =====
// ----------------------------------------------------------------------------
// Markup filter back end
// Takes decoded bytes from the queue, applies the tag and entity filter when
// enabled and drives the registered output, one result per cycle unless stalled.
// ----------------------------------------------------------------------------
module b64ms_back
  import b64ms_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         strip_markup,
  input  q_status_t    q_status,
  input  q_entry_t     head,
  output logic         pop,
  output back_status_t status,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   out_byte,
  output logic         out_run_last
);

  back_state_t       state;
  back_state_t       state_next;

  logic              inside_tag;
  logic              inside_tag_next;
  logic [6:0]        tag_head [HEAD_LEN];
  logic [6:0]        tag_head_next [HEAD_LEN];
  logic [TCNT_W-1:0] tag_count;
  logic [TCNT_W-1:0] tag_count_next;
  logic              inside_entity;
  logic              inside_entity_next;
  logic [6:0]        entity_chars [ENTITY_MAX];
  logic [ECNT_W-1:0] entity_count;
  logic [ECNT_W-1:0] entity_count_next;
  logic [ECNT_W-1:0] flush_idx;
  logic [ECNT_W-1:0] flush_idx_next;
  logic [ECNT_W-1:0] flush_count;
  logic [ECNT_W-1:0] flush_count_next;
  logic [7:0]        held_byte;
  logic [7:0]        held_byte_next;
  logic              held_emit;
  logic              held_emit_next;

  logic              emit_ok;
  logic              go;
  logic              emit;
  logic [7:0]        emit_data;
  logic              emit_last;
  logic              start_flush;
  logic              ent_we;
  logic [EIDX_W-1:0] ent_waddr;
  logic [6:0]        ent_wdata;
  logic              tag_newline;
  logic [7:0]        entity_sub;
  logic              tail_emit;
  logic              flush_end;
  logic [7:0]        b;
  logic [6:0]        b_lower;

  // A result may be loaded when the output register is free or draining.
  assign emit_ok         = !out_valid || out_ready;
  assign go              = (state == B_RUN) && !q_status.empty && emit_ok;
  assign status.pop      = pop;
  assign status.flushing = (state != B_RUN);

  // Decode of the current byte and of the filter's held state.
  always_comb begin
    b           = head.data;
    b_lower     = (b inside {["A":"Z"]}) ? 7'(b + 8'd32) : b[6:0];
    tail_emit   = (b != CH_LT) && (b != CH_AMP) && (b != CH_CR);
    flush_end   = (flush_idx == flush_count - ECNT_W'(1));
    tag_newline =
      ((tag_count >= TCNT_W'(2)) && ({1'b0, tag_head[0]} == "b") &&
       ({1'b0, tag_head[1]} == "r")) ||
      ((tag_count >= TCNT_W'(2)) && ({1'b0, tag_head[0]} == "/") &&
       ({1'b0, tag_head[1]} == "p")) ||
      ((tag_count >= TCNT_W'(4)) && ({1'b0, tag_head[0]} == "/") &&
       ({1'b0, tag_head[1]} == "d") && ({1'b0, tag_head[2]} == "i") &&
       ({1'b0, tag_head[3]} == "v")) ||
      ((tag_count >= TCNT_W'(3)) && ({1'b0, tag_head[0]} == "/") &&
       ({1'b0, tag_head[1]} == "l") && ({1'b0, tag_head[2]} == "i"));
    if ((entity_count == ECNT_W'(3)) && ({1'b0, entity_chars[0]} == "a") &&
        ({1'b0, entity_chars[1]} == "m") && ({1'b0, entity_chars[2]} == "p")) begin
      entity_sub = CH_AMP;
    end else if ((entity_count == ECNT_W'(2)) && ({1'b0, entity_chars[0]} == "l") &&
                 ({1'b0, entity_chars[1]} == "t")) begin
      entity_sub = CH_LT;
    end else if ((entity_count == ECNT_W'(2)) && ({1'b0, entity_chars[0]} == "g") &&
                 ({1'b0, entity_chars[1]} == "t")) begin
      entity_sub = CH_GT;
    end else begin
      entity_sub = CH_SP;
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      B_RUN: begin
        if (go && start_flush) begin
          if (entity_count != '0) begin
            state_next = B_FLUSH;
          end else if (tail_emit) begin
            state_next = B_TAIL;
          end
        end
      end
      B_FLUSH: begin
        if (emit_ok && flush_end) begin
          state_next = held_emit ? B_TAIL : B_RUN;
        end
      end
      B_TAIL: begin
        if (emit_ok) begin
          state_next = B_RUN;
        end
      end
      default: state_next = B_RUN;
    endcase
  end

  // Filter actions and results for each state.
  always_comb begin
    pop                = 1'b0;
    emit               = 1'b0;
    emit_data          = b;
    emit_last          = 1'b1;
    start_flush        = 1'b0;
    ent_we             = 1'b0;
    ent_waddr          = entity_count[EIDX_W-1:0];
    ent_wdata          = b[6:0];
    inside_tag_next    = inside_tag;
    tag_head_next      = tag_head;
    tag_count_next     = tag_count;
    inside_entity_next = inside_entity;
    entity_count_next  = entity_count;
    flush_idx_next     = flush_idx;
    flush_count_next   = flush_count;
    held_byte_next     = held_byte;
    held_emit_next     = held_emit;
    case (state)
      B_RUN: begin
        if (go) begin
          pop = 1'b1;
          if (head.has_byte) begin
            if (!strip_markup) begin
              emit = 1'b1;
            end else if (inside_tag) begin
              if (b == CH_GT) begin
                emit            = tag_newline;
                emit_data       = CH_LF;
                inside_tag_next = 1'b0;
                tag_count_next  = '0;
              end else if (!b[7] && (tag_count < TCNT_W'(TAG_MAX))) begin
                if (tag_count < TCNT_W'(HEAD_LEN)) begin
                  tag_head_next[tag_count[HEAD_IDX_W-1:0]] = b_lower;
                end
                tag_count_next = tag_count + TCNT_W'(1);
              end
            end else if (inside_entity && (b == CH_SEMI)) begin
              emit               = 1'b1;
              emit_data          = entity_sub;
              inside_entity_next = 1'b0;
              entity_count_next  = '0;
            end else if (inside_entity && !b[7] &&
                         (entity_count < ECNT_W'(ENTITY_MAX))) begin
              ent_we            = 1'b1;
              entity_count_next = entity_count + ECNT_W'(1);
            end else begin
              // Entity overflow or non-ASCII byte: '&' now, the held characters next.
              if (inside_entity) begin
                start_flush        = 1'b1;
                emit               = 1'b1;
                emit_data          = CH_AMP;
                emit_last          = (entity_count == '0) && !tail_emit;
                inside_entity_next = 1'b0;
                entity_count_next  = '0;
                flush_idx_next     = '0;
                flush_count_next   = entity_count;
                held_byte_next     = b;
                held_emit_next     = tail_emit;
              end
              // The byte itself is handled as plain text.
              if (b == CH_LT) begin
                inside_tag_next = 1'b1;
                tag_count_next  = '0;
              end else if (b == CH_AMP) begin
                inside_entity_next = 1'b1;
                entity_count_next  = '0;
              end else if ((b != CH_CR) && !inside_entity) begin
                emit = 1'b1;
              end
            end
          end
          // End of payload discards any open tag or entity.
          if (head.last) begin
            inside_tag_next    = 1'b0;
            tag_head_next      = '{default: '0};
            tag_count_next     = '0;
            inside_entity_next = 1'b0;
            entity_count_next  = '0;
          end
        end
      end
      B_FLUSH: begin
        if (emit_ok) begin
          emit           = 1'b1;
          emit_data      = {1'b0, entity_chars[flush_idx[EIDX_W-1:0]]};
          emit_last      = flush_end && !held_emit;
          flush_idx_next = flush_idx + ECNT_W'(1);
        end
      end
      B_TAIL: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_data = held_byte;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Held entity characters; only counted entries are ever read.
  always_ff @(posedge clk) begin
    if (ent_we) begin
      entity_chars[ent_waddr] <= ent_wdata;
    end
  end

  // Flush bookkeeping and output data.
  always_ff @(posedge clk) begin
    flush_idx   <= flush_idx_next;
    flush_count <= flush_count_next;
    held_byte   <= held_byte_next;
    held_emit   <= held_emit_next;
    out_byte    <= emit ? emit_data : out_byte;
    out_run_last <= emit ? emit_last : out_run_last;
  end

  // Control state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_RUN;
      inside_tag    <= 1'b0;
      tag_head      <= '{default: '0};
      tag_count     <= '0;
      inside_entity <= 1'b0;
      entity_count  <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      inside_tag    <= inside_tag_next;
      tag_head      <= tag_head_next;
      tag_count     <= tag_count_next;
      inside_entity <= inside_entity_next;
      entity_count  <= entity_count_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/base64_decode_markup_strip_unit.sv =====
// ----------------------------------------------------------------------------
// Base64 decode and markup strip unit
// Streaming base64 decoder with an optional tag and entity filter.
// ----------------------------------------------------------------------------
// The unit takes one encoded character per cycle on the input channel while
// its four-entry queue has room, and the filter delivers one result per cycle
// on the registered output channel while out_ready does not stall it. A
// character causes at most one decoded byte and, in the normal case, at most
// one result, registered as it leaves the queue; an entity that overflows or
// meets a non-ASCII byte is flushed raw, one result at a time through the
// single output port of the filter, up to sixteen results for one character.
// During such a flush the decoder keeps accepting characters until the queue
// fills. out_run_last marks the last result caused by one character.
// strip_markup may be written only while no work is in flight.
module base64_decode_markup_strip_unit
  import b64ms_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  logic         strip_markup;
  logic         push;
  q_entry_t     push_entry;
  q_entry_t     head;
  q_status_t    q_status;
  logic         pop;
  back_status_t back_status;

  // Configuration register: every write transfer is taken at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_markup <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      strip_markup <= cfg_data;
    end
  end

  // Decoder front end.
  b64ms_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_char    (in_char),
    .in_last    (in_last),
    .push       (push),
    .push_entry (push_entry),
    .q_status   (q_status)
  );

  // Queue between the two ends.
  b64ms_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // Filter back end.
  b64ms_back u_back (
    .clk          (clk),
    .rst          (rst),
    .strip_markup (strip_markup),
    .q_status     (q_status),
    .head         (head),
    .pop          (pop),
    .status       (back_status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

`ifndef SYNTHESIS
  // An entity flush can only arise with the filter enabled.
  assert property (@(posedge clk) disable iff (rst)
    back_status.flushing |-> strip_markup)
    else $error("entity flush while markup stripping is off");

  // The back end never takes an entry from an empty queue.
  assert property (@(posedge clk) disable iff (rst)
    back_status.pop |-> !q_status.empty)
    else $error("pop from an empty queue");

  // Occupancy stays within the queue depth.
  assert property (@(posedge clk) disable iff (rst)
    q_status.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy beyond its depth");
`endif

endmodule
